// ===== sv/dna_sequence_complexity_score_core_macros.svh =====
// assertion helpers shared by the core's modules
`ifndef DNA_SEQUENCE_COMPLEXITY_SCORE_CORE_MACROS_SVH
`define DNA_SEQUENCE_COMPLEXITY_SCORE_CORE_MACROS_SVH

// same-cycle implication
`define DSCS_ASSERT_NOW(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// next-cycle implication
`define DSCS_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

// ===== sv/dscs_pkg.sv =====
package dscs_pkg;

   localparam int MAX_LEN   = 4096;
   localparam int FRAC_BITS = 16;

   localparam int SYM_W     = 8;
   localparam int LEN_W     = $clog2(MAX_LEN + 1);
   localparam int LOG_FRAC  = 32;
   localparam int LOG_SH_W  = $clog2(LOG_FRAC);
   localparam int EXP_W     = $clog2(LEN_W);
   localparam int LF_INT_W  = LEN_W + EXP_W;
   localparam int LF_W      = LF_INT_W + LOG_FRAC;
   localparam int DIV_W     = LEN_W + 1;
   localparam int STEP_W    = $clog2(LF_W);
   localparam int SCORE_W   = FRAC_BITS + 1;

   localparam logic [SCORE_W-1:0] SCORE_ONE = SCORE_W'(1) << FRAC_BITS;

   localparam int NUM_BASES = 4;
   localparam int BASE_A    = 0;
   localparam int BASE_C    = 1;
   localparam int BASE_G    = 2;
   localparam int BASE_T    = 3;

   localparam logic [SYM_W-1:0] BASE_CHAR [NUM_BASES] = '{8'h41, 8'h43, 8'h47, 8'h54};

   typedef struct packed {
      logic fill_init;
      logic fill_load;
      logic fill_square;
      logic fill_write;
      logic count;
      logic sum_start;
      logic sum_step;
      logic div_start;
      logic div_step;
      logic load_result;
   } dscs_cmd_type;

   typedef struct packed {
      logic fill_end;
      logic sq_last;
      logic sum_done;
      logic div_last;
   } dscs_stat_type;

endpackage

// ===== sv/dscs_if.sv =====
interface dscs_req_if;
   import dscs_pkg::*;

   logic             valid;
   logic             ready;
   logic [SYM_W-1:0] symbol;
   logic             last;

   modport source (output valid, symbol, last, input ready);
   modport sink (input valid, symbol, last, output ready);
endinterface

interface dscs_rsp_if;
   import dscs_pkg::*;

   logic               valid;
   logic               ready;
   logic [SCORE_W-1:0] score;
   logic [LEN_W-1:0]   seq_length;
   logic               empty_flag;
   logic               overflow_flag;

   modport source (output valid, score, seq_length, empty_flag, overflow_flag, input ready);
   modport sink (input valid, score, seq_length, empty_flag, overflow_flag, output ready);
endinterface

// ===== sv/dna_sequence_complexity_score_core.sv =====
// Wootton-Federhen complexity score of a byte stream. Sequence bytes enter on req_bus one per
// cycle while req_bus.ready is high; the byte flagged last closes the sequence and produces one
// result on rsp_bus: the score log4(N!/(A!C!G!T!))/N with FRAC_BITS fraction bits (rounded half
// up, limited to 1.0), the length (saturating at MAX_LEN, with overflow_flag set when bytes were
// dropped) and empty_flag. Only exact uppercase A, C, G and T are counted as bases; every byte
// adds to the length. After reset the block builds its log2(k!) table in a memory, one entry at a
// time through a single 32x32 squaring unit, and req_bus.ready stays low until the table is
// complete. After the last byte of a sequence ready stays low while the block reads the five
// table terms through the one read port, starts a radix-2 divider giving one quotient bit per
// cycle over the 49-bit log difference, and loads the output register once that register is
// free. A finished result sits in the output register, so the next sequence may stream in while
// it waits.
module dna_sequence_complexity_score_core (
   input  logic clock,
   input  logic reset,
   dscs_req_if.sink   req_bus,
   dscs_rsp_if.source rsp_bus
);
   import dscs_pkg::*;

   dscs_cmd_type  cmd;
   dscs_stat_type stat;

   dscs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_last  (req_bus.last),
      .req_ready (req_bus.ready),
      .rsp_ready (rsp_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .cmd       (cmd),
      .stat      (stat)
   );

   dscs_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .symbol        (req_bus.symbol),
      .stat          (stat),
      .score         (rsp_bus.score),
      .seq_length    (rsp_bus.seq_length),
      .empty_flag    (rsp_bus.empty_flag),
      .overflow_flag (rsp_bus.overflow_flag)
   );

endmodule

// ===== sv/dscs_ctrl.sv =====
`include "dna_sequence_complexity_score_core_macros.svh"

module dscs_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_last,
   output logic                   req_ready,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output dscs_pkg::dscs_cmd_type cmd,
   input  dscs_pkg::dscs_stat_type stat
);
   import dscs_pkg::*;

   localparam logic [2:0] ST_FILL_INIT  = 3'd0;
   localparam logic [2:0] ST_FILL_LOAD  = 3'd1;
   localparam logic [2:0] ST_FILL_SQ    = 3'd2;
   localparam logic [2:0] ST_FILL_WRITE = 3'd3;
   localparam logic [2:0] ST_IDLE       = 3'd4;
   localparam logic [2:0] ST_SUM        = 3'd5;
   localparam logic [2:0] ST_DIV_INIT   = 3'd6;
   localparam logic [2:0] ST_DIV        = 3'd7;
   localparam logic [2:0] ST_DONE_WAIT  = 3'd0;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       done_ff;
   logic       done_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;

   always_comb begin
      state_in  = state_ff;
      done_in   = done_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_FILL_INIT: begin
            if (done_ff) begin
               // result waiting for the output register
               if (!rsp_valid_ff || rsp_ready) begin
                  cmd.load_result = 1'b1;
                  done_in         = 1'b0;
                  state_in        = ST_IDLE;
               end
            end else begin
               cmd.fill_init = 1'b1;
               state_in      = ST_FILL_LOAD;
            end
         end
         ST_FILL_LOAD: begin
            cmd.fill_load = 1'b1;
            state_in      = ST_FILL_SQ;
         end
         ST_FILL_SQ: begin
            cmd.fill_square = 1'b1;
            if (stat.sq_last) begin
               state_in = ST_FILL_WRITE;
            end
         end
         ST_FILL_WRITE: begin
            cmd.fill_write = 1'b1;
            state_in       = stat.fill_end ? ST_IDLE : ST_FILL_LOAD;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.count = 1'b1;
               if (req_last) begin
                  cmd.sum_start = 1'b1;
                  state_in      = ST_SUM;
               end
            end
         end
         ST_SUM: begin
            cmd.sum_step = 1'b1;
            if (stat.sum_done) begin
               state_in = ST_DIV_INIT;
            end
         end
         ST_DIV_INIT: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               done_in  = 1'b1;
               state_in = ST_DONE_WAIT;
            end
         end
         default: begin
            state_in = ST_FILL_INIT;
         end
      endcase
   end

   assign rsp_valid_in = cmd.load_result | (rsp_valid_ff & ~rsp_ready);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FILL_INIT;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `DSCS_ASSERT_NEXT(a_last_starts_sum, req_valid && req_ready && req_last, state_ff == ST_SUM, "last word did not start scoring")
   `DSCS_ASSERT_NOW(a_rsp_rise_from_load, $rose(rsp_valid_ff), $past(done_ff), "result shown without a finished score")
   `DSCS_ASSERT_NOW(a_no_req_while_scoring, done_ff, !req_ready, "input taken while a score waits")

endmodule

// ===== sv/dscs_dp.sv =====
`include "dna_sequence_complexity_score_core_macros.svh"

module dscs_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  dscs_pkg::dscs_cmd_type        cmd,
   input  logic [dscs_pkg::SYM_W-1:0]    symbol,
   output dscs_pkg::dscs_stat_type       stat,
   output logic [dscs_pkg::SCORE_W-1:0]  score,
   output logic [dscs_pkg::LEN_W-1:0]    seq_length,
   output logic                          empty_flag,
   output logic                          overflow_flag
);
   import dscs_pkg::*;

   localparam logic [2:0] SEL_LEN = 3'd0;
   localparam logic [2:0] SEL_A   = 3'd1;
   localparam logic [2:0] SEL_C   = 3'd2;
   localparam logic [2:0] SEL_G   = 3'd3;
   localparam logic [2:0] SEL_T   = 3'd4;
   localparam logic [2:0] SEL_END = 3'd5;

   localparam int SH_W = LF_W + 1 - (LOG_FRAC - FRAC_BITS);
   localparam logic [LF_W:0] RND_ADD = (LF_W + 1)'(1) << (LOG_FRAC - 1 - FRAC_BITS);

   // live sequence counters
   logic [LEN_W-1:0]      len_ff;
   logic [LEN_W-1:0]      len_in;
   logic [LEN_W-1:0]      base_ff [NUM_BASES];
   logic [LEN_W-1:0]      base_in [NUM_BASES];
   logic                  sat_ff;
   logic                  sat_in;
   logic [NUM_BASES-1:0]  hit;

   // log-factorial table and its fill
   logic [LF_W-1:0]       lf_mem [0:MAX_LEN];
   logic                  mem_we;
   logic [LEN_W-1:0]      mem_waddr;
   logic [LF_W-1:0]       mem_wdata;
   logic [LEN_W-1:0]      mem_raddr;
   logic [LF_W-1:0]       rd_ff;
   logic [LEN_W-1:0]      k_ff;
   logic [LF_W-1:0]       acc_ff;
   logic [LF_W-1:0]       acc_sum;
   logic [EXP_W-1:0]      e_ff;
   logic [EXP_W-1:0]      e_comb;
   logic [LOG_FRAC-1:0]   m_ff;
   logic [LOG_FRAC-1:0]   m_init;
   logic [LOG_FRAC-1:0]   m_sq;
   logic [LOG_FRAC-1:0]   frac_ff;
   logic [2*LOG_FRAC-1:0] sq;
   logic [LOG_FRAC:0]     sq_top;
   logic [STEP_W-1:0]     step_ff;

   // log term sum and divider
   logic [2:0]            sel_ff;
   logic [LF_W-1:0]       top_ff;
   logic [LF_W-1:0]       sub_ff;
   logic [LF_W-1:0]       diff;
   logic [DIV_W-1:0]      divisor_ff;
   logic [DIV_W-1:0]      rem_ff;
   logic [DIV_W:0]        trial;
   logic                  q_bit;
   logic [LF_W-1:0]       quo_ff;

   // result register
   logic [LF_W:0]         rnd;
   logic [SH_W-1:0]       rnd_sh;
   logic [SCORE_W-1:0]    score_in;
   logic [SCORE_W-1:0]    score_ff;
   logic [LEN_W-1:0]      seq_length_ff;
   logic                  empty_ff;
   logic                  overflow_ff;

   always_comb begin
      for (int b = 0; b < NUM_BASES; b++) begin
         hit[b] = (symbol == BASE_CHAR[b]);
      end
   end

   always_comb begin
      len_in = len_ff;
      sat_in = sat_ff;
      for (int b = 0; b < NUM_BASES; b++) begin
         base_in[b] = base_ff[b];
      end
      if (cmd.load_result) begin
         len_in = '0;
         sat_in = 1'b0;
         for (int b = 0; b < NUM_BASES; b++) begin
            base_in[b] = '0;
         end
      end else if (cmd.count) begin
         if (len_ff == LEN_W'(MAX_LEN)) begin
            sat_in = 1'b1;
         end else begin
            len_in = len_ff + LEN_W'(1);
            for (int b = 0; b < NUM_BASES; b++) begin
               if (hit[b]) begin
                  base_in[b] = base_ff[b] + LEN_W'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
         sat_ff <= 1'b0;
         for (int b = 0; b < NUM_BASES; b++) begin
            base_ff[b] <= '0;
         end
      end else begin
         len_ff <= len_in;
         sat_ff <= sat_in;
         for (int b = 0; b < NUM_BASES; b++) begin
            base_ff[b] <= base_in[b];
         end
      end
   end

   // leading one of k gives the integer part of log2
   always_comb begin
      e_comb = '0;
      for (int i = 0; i < LEN_W; i++) begin
         if (k_ff[i]) begin
            e_comb = EXP_W'(i);
         end
      end
   end

   assign m_init  = LOG_FRAC'(k_ff) << (LOG_SH_W'(LOG_FRAC - 1) - LOG_SH_W'(e_comb));
   assign sq      = {LOG_FRAC'(0), m_ff} * {LOG_FRAC'(0), m_ff};
   assign sq_top  = sq[2*LOG_FRAC-1:LOG_FRAC-1];
   assign m_sq    = sq_top[LOG_FRAC] ? sq_top[LOG_FRAC:1] : sq_top[LOG_FRAC-1:0];
   assign acc_sum = acc_ff + LF_W'({e_ff, frac_ff});

   assign mem_we    = cmd.fill_init | cmd.fill_write;
   assign mem_waddr = cmd.fill_init ? '0 : k_ff;
   assign mem_wdata = cmd.fill_init ? '0 : acc_sum;

   always_comb begin
      unique case (sel_ff)
         SEL_LEN: mem_raddr = len_ff;
         SEL_A:   mem_raddr = base_ff[BASE_A];
         SEL_C:   mem_raddr = base_ff[BASE_C];
         SEL_G:   mem_raddr = base_ff[BASE_G];
         SEL_T:   mem_raddr = base_ff[BASE_T];
         default: mem_raddr = len_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         lf_mem[mem_waddr] <= mem_wdata;
      end
      rd_ff <= lf_mem[mem_raddr];
   end

   assign diff  = (top_ff > sub_ff) ? (top_ff - sub_ff) : '0;
   assign trial = {rem_ff, quo_ff[LF_W-1]};
   assign q_bit = (trial >= {1'b0, divisor_ff});

   always_ff @(posedge clock) begin
      if (cmd.fill_init) begin
         k_ff   <= LEN_W'(1);
         acc_ff <= '0;
      end else if (cmd.fill_write) begin
         k_ff   <= k_ff + LEN_W'(1);
         acc_ff <= acc_sum;
      end
      if (cmd.fill_load) begin
         e_ff    <= e_comb;
         m_ff    <= m_init;
         frac_ff <= '0;
      end else if (cmd.fill_square) begin
         m_ff    <= m_sq;
         frac_ff <= {frac_ff[LOG_FRAC-2:0], sq_top[LOG_FRAC]};
      end
      if (cmd.fill_load || cmd.div_start) begin
         step_ff <= '0;
      end else if (cmd.fill_square || cmd.div_step) begin
         step_ff <= step_ff + STEP_W'(1);
      end
      if (cmd.sum_start) begin
         sel_ff <= SEL_LEN;
         sub_ff <= '0;
      end else if (cmd.sum_step) begin
         sel_ff <= sel_ff + 3'd1;
         // table data comes through the read register rd_ff, so it trails its address
         if (sel_ff == SEL_A) begin
            top_ff <= rd_ff;
         end else if (sel_ff != SEL_LEN) begin
            sub_ff <= sub_ff + rd_ff;
         end
      end
      if (cmd.div_start) begin
         quo_ff     <= diff;
         rem_ff     <= '0;
         divisor_ff <= {len_ff, 1'b0};
      end else if (cmd.div_step) begin
         quo_ff <= {quo_ff[LF_W-2:0], q_bit};
         rem_ff <= q_bit ? DIV_W'(trial - {1'b0, divisor_ff}) : DIV_W'(trial);
      end
   end

   // round half up, limit to one
   assign rnd    = {1'b0, quo_ff} + RND_ADD;
   assign rnd_sh = rnd[LF_W:LOG_FRAC-FRAC_BITS];

   always_comb begin
      if (len_ff == '0) begin
         score_in = '0;
      end else if (rnd_sh > SH_W'(SCORE_ONE)) begin
         score_in = SCORE_ONE;
      end else begin
         score_in = SCORE_W'(rnd_sh);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_result) begin
         score_ff      <= score_in;
         seq_length_ff <= len_ff;
         empty_ff      <= (len_ff == '0);
         overflow_ff   <= sat_ff;
      end
   end

   assign score         = score_ff;
   assign seq_length    = seq_length_ff;
   assign empty_flag    = empty_ff;
   assign overflow_flag = overflow_ff;

   assign stat.fill_end = (k_ff == LEN_W'(MAX_LEN));
   assign stat.sq_last  = (step_ff == STEP_W'(LOG_FRAC - 1));
   assign stat.sum_done = (sel_ff == SEL_END);
   assign stat.div_last = (step_ff == STEP_W'(LF_W - 1));

   `DSCS_ASSERT_NOW(a_len_bound, 1'b1, len_ff <= LEN_W'(MAX_LEN), "length count above limit")
   `DSCS_ASSERT_NOW(a_bases_in_len, 1'b1, (LEN_W + 2)'(base_ff[BASE_A]) + (LEN_W + 2)'(base_ff[BASE_C]) + (LEN_W + 2)'(base_ff[BASE_G]) + (LEN_W + 2)'(base_ff[BASE_T]) <= (LEN_W + 2)'(len_ff), "base counts exceed length")
   `DSCS_ASSERT_NOW(a_rem_below_divisor, cmd.div_step, rem_ff < divisor_ff, "divider remainder out of range")
   `DSCS_ASSERT_NEXT(a_score_limited, cmd.load_result, score_ff <= SCORE_ONE, "score above one")

endmodule

// ===== verif/dna_sequence_complexity_score_core_checker.sv =====
`timescale 1ns / 1ps

module dna_sequence_complexity_score_core_checker (
   input  logic        clock,
   input  logic        reset,
   dscs_req_if         req_mon,
   dscs_rsp_if         rsp_mon,
   output int unsigned mismatch_count,
   output int unsigned pending_count
);
   import dscs_pkg::*;

   typedef struct packed {
      logic [SCORE_W-1:0] score;
      logic [LEN_W-1:0]   seq_length;
      logic               empty_flag;
      logic               overflow_flag;
   } score_word_type;

   bit [63:0]      log_fact_table [0:MAX_LEN];
   int unsigned    base_tally [NUM_BASES];
   int unsigned    seq_len;
   bit             len_saturated;
   score_word_type expected_scores [$];

   // log2(v) with 32 fraction bits, truncated, by repeated squaring
   function automatic bit [63:0] log2_fixed(input int unsigned v);
      int unsigned ex;
      int          bit_pos;
      bit [63:0]   mant;
      bit [63:0]   frac;
      ex   = 0;
      frac = '0;
      while (ex < 31 && (v >> (ex + 1)) != 0)
         ex++;
      mant = (64'(v) << (31 - ex)) & 64'hFFFF_FFFF;
      mant |= 64'h8000_0000;
      for (bit_pos = 31; bit_pos >= 0; bit_pos--) begin
         mant = (mant * mant) >> 31;
         if (mant >= 64'h1_0000_0000) begin
            mant >>= 1;
            frac[bit_pos] = 1'b1;
         end
      end
      return (64'(ex) << 32) | frac;
   endfunction

   function automatic score_word_type predict_score(input int unsigned n,
                                                    input int unsigned tally [NUM_BASES],
                                                    input bit sat);
      score_word_type r;
      bit [63:0]      top_lf;
      bit [63:0]      sub_lf;
      bit [63:0]      diff;
      bit [63:0]      quot;
      bit [63:0]      rounded;
      int             i;
      r.seq_length    = LEN_W'(n);
      r.overflow_flag = sat;
      r.empty_flag    = (n == 0);
      r.score         = '0;
      if (n != 0) begin
         top_lf = log_fact_table[n];
         sub_lf = '0;
         for (i = 0; i < NUM_BASES; i++)
            sub_lf += log_fact_table[tally[i]];
         diff    = (top_lf > sub_lf) ? top_lf - sub_lf : 64'd0;
         quot    = diff / (64'(n) * 2);
         rounded = (quot + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
         if (rounded > 64'(SCORE_ONE))
            rounded = 64'(SCORE_ONE);
         r.score = SCORE_W'(rounded);
      end
      return r;
   endfunction

   function automatic void check_field(input string name, input longint unsigned want,
                                       input longint unsigned got);
      if (want != got) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
   endfunction

   initial begin : build_table
      bit [63:0]   acc;
      int unsigned k;
      mismatch_count    = 0;
      pending_count     = 0;
      acc               = '0;
      log_fact_table[0] = '0;
      for (k = 1; k <= MAX_LEN; k++) begin
         acc += log2_fixed(k);
         log_fact_table[k] = acc;
      end
   end

   always @(posedge clock) begin : watch
      score_word_type want;
      int             i;
      if (reset) begin
         foreach (base_tally[i])
            base_tally[i] = 0;
         seq_len       = 0;
         len_saturated = 1'b0;
         expected_scores.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_scores.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected result word, expected none, got score %0d length %0d",
                        $time, rsp_mon.score, rsp_mon.seq_length);
            end else begin
               want = expected_scores.pop_front();
               check_field("score", want.score, rsp_mon.score);
               check_field("seq_length", want.seq_length, rsp_mon.seq_length);
               check_field("empty_flag", want.empty_flag, rsp_mon.empty_flag);
               check_field("overflow_flag", want.overflow_flag, rsp_mon.overflow_flag);
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            if (seq_len >= MAX_LEN) begin
               len_saturated = 1'b1;
            end else begin
               seq_len++;
               for (i = 0; i < NUM_BASES; i++)
                  if (req_mon.symbol == BASE_CHAR[i])
                     base_tally[i]++;
            end
            if (req_mon.last) begin
               expected_scores.push_back(predict_score(seq_len, base_tally, len_saturated));
               foreach (base_tally[i])
                  base_tally[i] = 0;
               seq_len       = 0;
               len_saturated = 1'b0;
            end
         end
      end
      pending_count <= expected_scores.size();
   end

endmodule

// ===== verif/dna_sequence_complexity_score_core_tb.sv =====
`timescale 1ns / 1ps

module dna_sequence_complexity_score_core_tb;
   import dscs_pkg::*;

   localparam int unsigned RSP_HOLD_CYCLES = 400;
   localparam int unsigned RANDOM_ITEMS    = 650;

   logic        clock;
   logic        reset;
   bit          src_idle_on;
   bit          snk_idle_on;
   bit          rsp_hold;
   int unsigned mismatch_count;
   int unsigned pending_count;

   dscs_req_if req_bus ();
   dscs_rsp_if rsp_bus ();

   dna_sequence_complexity_score_core u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   dna_sequence_complexity_score_core_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   initial begin
      clock          = 1'b0;
      reset          = 1'b1;
      src_idle_on    = 1'b1;
      snk_idle_on    = 1'b1;
      rsp_hold       = 1'b0;
      req_bus.valid  = 1'b0;
      req_bus.symbol = '0;
      req_bus.last   = 1'b0;
      rsp_bus.ready  = 1'b0;
   end

   always #5 clock = ~clock;

   initial begin
      #10_000_000;
      $display("Test completed with failures");
      $finish;
   end

   task automatic send_byte(input logic [SYM_W-1:0] sym, input logic fin);
      int unsigned gap;
      gap = src_idle_on ? $urandom_range(0, 4) : 0;
      @(negedge clock);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid  <= 1'b1;
      req_bus.symbol <= sym;
      req_bus.last   <= fin;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic send_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++)
         send_byte(s[i], i == s.len() - 1);
   endtask

   // bases come from a random subset of A, C, G, T; other_pct of the words are any byte
   task automatic send_random_seq(input int unsigned len, input int unsigned other_pct);
      int unsigned      pool;
      int unsigned      offset;
      int unsigned      i;
      logic [SYM_W-1:0] sym;
      pool   = $urandom_range(1, NUM_BASES);
      offset = $urandom_range(0, NUM_BASES - 1);
      for (i = 0; i < len; i++) begin
         if ($urandom_range(0, 99) < other_pct)
            sym = SYM_W'($urandom_range(0, 255));
         else
            sym = BASE_CHAR[(offset + $urandom_range(0, pool - 1)) % NUM_BASES];
         send_byte(sym, i == len - 1);
      end
   endtask

   // result side
   initial begin : sink
      int unsigned gap;
      forever begin
         gap = snk_idle_on ? $urandom_range(0, 4) : 0;
         if (rsp_hold) begin
            gap      = RSP_HOLD_CYCLES;
            rsp_hold = 1'b0;
         end
         @(negedge clock);
         if (gap != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid && rsp_bus.ready));
      end
   end

   initial begin : stimulus
      int unsigned items_sent;
      int unsigned len;
      int unsigned pick;
      bit          pressure_done;
      items_sent    = 0;
      pressure_done = 1'b0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // directed sequences
      send_text("A");
      send_byte(8'hFF, 1'b1);
      send_text("ACGT");
      send_text("AAAA");
      send_text("acgt");
      send_byte(8'h00, 1'b0);
      send_text("GT");
      send_byte(8'hFF, 1'b0);
      send_text("CCA");
      send_text("TTGG");

      // full length and over length
      send_random_seq(MAX_LEN, 5);
      send_random_seq(MAX_LEN + 3, 5);

      while (items_sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 7) == 0) begin
            src_idle_on = ($urandom_range(0, 3) != 0);
            snk_idle_on = ($urandom_range(0, 3) != 0);
         end
         if (!pressure_done && items_sent >= RANDOM_ITEMS / 2) begin
            pressure_done = 1'b1;
            src_idle_on   = 1'b0;
            rsp_hold      = 1'b1;
            repeat (8) send_random_seq(3, 0);
            items_sent += 24;
         end
         pick = $urandom_range(0, 99);
         if (pick < 80)
            len = $urandom_range(1, 12);
         else if (pick < 95)
            len = $urandom_range(13, 64);
         else
            len = $urandom_range(65, 300);
         if ($urandom_range(0, 3) == 0)
            send_random_seq(len, $urandom_range(50, 100));
         else
            send_random_seq(len, $urandom_range(0, 10));
         items_sent += len;
      end

      @(negedge clock);
      req_bus.valid <= 1'b0;
      wait (pending_count == 0);
      repeat (100) @(posedge clock);
      if (mismatch_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+sv
sv/dscs_pkg.sv
sv/dscs_if.sv
sv/dscs_ctrl.sv
sv/dscs_dp.sv
sv/dna_sequence_complexity_score_core.sv
verif/dna_sequence_complexity_score_core_checker.sv
verif/dna_sequence_complexity_score_core_tb.sv
